// ===== design/bgla_pkg.sv =====
// Shared types, constants and arithmetic helpers of the battery gauge low alarm block.
package bgla_pkg;

	typedef enum logic [1:0] {
		REQ_SAMPLE     = 2'd0,
		REQ_CONNECT    = 2'd1,
		REQ_DISCONNECT = 2'd2,
		REQ_DEBOUNCE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STAGE_ARMED = 3'b001,
		STAGE_READY = 3'b010,
		STAGE_IDLE  = 3'b100
	} stage_t;

	localparam int SampleBits = 10;
	localparam int VoltBits   = 13;
	localparam int PctBits    = 7;
	localparam int SecsBits   = 12;

	localparam logic [VoltBits-1:0] FLOOR_MV  = 13'd3498;
	localparam logic [PctBits-1:0]  PCT_MAX   = 7'd100;
	localparam logic [7:0]          OFS_HIGH  = 8'h2c;
	localparam logic [7:0]          OFS_LOW   = 8'd3;
	localparam logic [7:0]          OFS_STEP  = 8'd3;
	localparam logic [SecsBits-1:0] SECS_PER_PCT = 12'd30;
	localparam logic [SecsBits-1:0] SECS_BASE    = 12'd600;

	// Input word as held in the first pipeline register: the sample is already scaled.
	typedef struct packed {
		req_t                req_type;
		logic [VoltBits-1:0] volt;
		logic                usb_present;
		logic                powered;
	} item_t;

	typedef struct packed {
		logic [PctBits-1:0]  battery_percent;
		logic                low_alert;
		logic                shutdown_request;
		logic [SecsBits-1:0] full_charge_seconds;
	} result_t;

	// 4*s + (2*s)/10 + (2*s)/100. The divisions are reciprocal multiplies that are
	// exact over the whole 11-bit range of 2*s.
	function automatic logic [VoltBits-1:0] scale_sample(input logic [SampleBits-1:0] s);
		logic [SampleBits:0] two_s;
		logic [22:0]         p10;
		logic [23:0]         p100;
		logic [7:0]          q10;
		logic [4:0]          q100;
		two_s = {s, 1'b0};
		p10   = 23'(two_s) * 23'd3277;
		p100  = 24'(two_s) * 24'd5243;
		q10   = p10[22:15];
		q100  = p100[23:19];
		return {1'b0, s, 2'b00} + VoltBits'(q10) + VoltBits'(q100);
	endfunction

	// Maps the scaled value to a corrected, capped percent. (v - floor) / 6 is a
	// multiply by 683 and a shift by 12, exact for spans below 1024.
	function automatic logic [PctBits-1:0] raw_percent(input logic [VoltBits-1:0] volt);
		logic [9:0]  span;
		logic [19:0] prod;
		logic [7:0]  c;
		span = (volt < FLOOR_MV) ? 10'd0 : 10'(volt - FLOOR_MV);
		prod = 20'(span) * 20'd683;
		c    = prod[19:12];
		if (c > OFS_HIGH) begin
			c = c + OFS_STEP;
		end else if (c > OFS_LOW) begin
			c = c - OFS_STEP;
		end else begin
			c = 8'd0;
		end
		if (c > 8'(PCT_MAX)) begin
			c = 8'(PCT_MAX);
		end
		return c[PctBits-1:0];
	endfunction

endpackage

// ===== design/bgla_req_if.sv =====
// Request channel interface: one battery event word per handshake.
interface bgla_req_if
	import bgla_pkg::*;
();
	logic                  valid;
	logic                  ready;
	req_t                  req_type;
	logic [SampleBits-1:0] adc_sample;
	logic                  usb_present;
	logic                  powered;

	modport source (output valid, req_type, adc_sample, usb_present, powered, input ready);
	modport sink   (input valid, req_type, adc_sample, usb_present, powered, output ready);
endinterface

// ===== design/bgla_rsp_if.sv =====
// Result channel interface: one gauge result word per handshake.
interface bgla_rsp_if
	import bgla_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [PctBits-1:0]  battery_percent;
	logic                low_alert;
	logic                shutdown_request;
	logic [SecsBits-1:0] full_charge_seconds;

	modport source (output valid, battery_percent, low_alert, shutdown_request,
		full_charge_seconds, input ready);
	modport sink   (input valid, battery_percent, low_alert, shutdown_request,
		full_charge_seconds, output ready);
endinterface

// ===== design/bgla_state.sv =====
// Gauge state: kept percent, one-shot alarm flags and the alert counter.
module bgla_state
	import bgla_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  item_t   item,
	output result_t result
);

	logic [PctBits-1:0] kept_q;
	logic [2:0]         flags_q;
	stage_t             stage_q;

	logic [PctBits-1:0] c;
	logic [PctBits-1:0] base;
	logic [PctBits-1:0] upd;
	logic [PctBits-1:0] k;
	logic               active;
	logic               run_update;
	logic               run_alarm;
	logic               arm20;
	logic               arm10;
	logic               arm5;
	stage_t             stage_mid;
	logic               alert;
	logic               shut;
	logic [PctBits-1:0] kept_d;
	logic [2:0]         flags_d;
	stage_t             stage_d;
	logic [SecsBits-1:0] secs;

	assign c      = raw_percent(item.volt);
	assign active = !item.usb_present && item.powered;

	// A disconnect restarts the percent, so it seeds from the new reading.
	always_comb begin
		base = (item.req_type == REQ_DISCONNECT) ? '0 : kept_q;
		if (base == '0) begin
			upd = c;
		end else if (c < base) begin
			upd = ((base - c) < 7'd3) ? base - 7'd1 : base - 7'd2;
		end else begin
			upd = base;
		end
	end

	assign run_update = (item.req_type == REQ_DISCONNECT) ||
		(item.req_type == REQ_SAMPLE && active);
	assign run_alarm  = active &&
		(item.req_type == REQ_SAMPLE || item.req_type == REQ_DISCONNECT);
	assign k = run_update ? upd : kept_q;

	assign arm20 = (k >= 7'd19) && (k <= 7'd21) && !flags_q[0];
	assign arm10 = (k >= 7'd9)  && (k <= 7'd11) && !flags_q[1];
	assign arm5  = !arm10 && (k >= 7'd3) && (k <= 7'd6) && !flags_q[2];

	always_comb begin
		kept_d    = kept_q;
		flags_d   = flags_q;
		stage_d   = stage_q;
		stage_mid = stage_q;
		alert     = 1'b0;
		shut      = 1'b0;
		secs      = '0;
		case (item.req_type)
			REQ_SAMPLE, REQ_DISCONNECT: begin
				kept_d = k;
				if (run_alarm) begin
					flags_d = flags_q | {arm5, arm10, arm20};
					if (arm20 || arm10 || arm5) begin
						stage_mid = STAGE_ARMED;
					end
					case (stage_mid)
						STAGE_READY: begin
							stage_d = STAGE_IDLE;
							alert   = 1'b1;
						end
						STAGE_ARMED: begin
							stage_d = STAGE_READY;
						end
						default: begin
							stage_d = stage_mid;
							shut    = (k < 7'd2);
						end
					endcase
				end
			end
			REQ_CONNECT: begin
				flags_d = '0;
				stage_d = STAGE_IDLE;
			end
			default: begin
				if (item.usb_present) begin
					secs = SecsBits'(PCT_MAX - kept_q) * SECS_PER_PCT + SECS_BASE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q  <= '0;
			flags_q <= '0;
			stage_q <= STAGE_IDLE;
		end else if (step_en) begin
			kept_q  <= kept_d;
			flags_q <= flags_d;
			stage_q <= stage_d;
		end
	end

	assign result.battery_percent     = kept_d;
	assign result.low_alert           = alert;
	assign result.shutdown_request    = shut;
	assign result.full_charge_seconds = secs;

`ifndef SYNTH
	a_kept_cap: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= PCT_MAX)
		else $error("kept percent above full scale");

	a_kept_falls: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && item.req_type != REQ_DISCONNECT && kept_q != '0) |=>
		(kept_q <= $past(kept_q)))
		else $error("kept percent rose without a restart");

	a_alert_from_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && result.low_alert) |-> (stage_q == STAGE_READY))
		else $error("low alert without a ready counter");

	a_alert_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && result.low_alert) |=> (stage_q == STAGE_IDLE))
		else $error("counter not idle after alert");
`endif

endmodule

// ===== design/battery_gauge_low_alarm_top.sv =====
// Battery gauge with low-battery alarms: input register, gauge state and result register.
// An accepted word is held in the input register, then moves into the result register.
// Throughput: one word per cycle; a stalled result lets in one more word, then input stalls.
// The scaled sample is formed before the input register, and the percent mapping and
// the state update sit between the input register and the result register.
// Reset (arst_n, asynchronous, active low) empties both registers, zeroes the kept
// percent, clears the alarm flags and leaves the alert counter idle.
module battery_gauge_low_alarm_top
	import bgla_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	bgla_req_if.sink   req,
	bgla_rsp_if.source rsp
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result;
	logic    advance;
	logic    step_en;

	// The result register moves when it is empty or its word is being taken; the
	// input register then frees up in the same cycle, so the two sides never wait
	// on each other beyond one word.
	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign step_en   = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// The scale step of the sample uses two small reciprocal multiplies, so it is
	// done on the way into the input register.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type    <= req.req_type;
			item_s1.volt        <= scale_sample(req.adc_sample);
			item_s1.usb_present <= req.usb_present;
			item_s1.powered     <= req.powered;
		end
	end

	// Percent mapping, smoothing and the alarm counter; the state commits only
	// when the word moves on into the result register.
	bgla_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid               = valid_s2;
	assign rsp.battery_percent     = result_s2.battery_percent;
	assign rsp.low_alert           = result_s2.low_alert;
	assign rsp.shutdown_request    = result_s2.shutdown_request;
	assign rsp.full_charge_seconds = result_s2.full_charge_seconds;

endmodule

// ===== dv/tb_battery_gauge_low_alarm_top.sv =====
// Testbench for the battery gauge low alarm block: directed table, random words, gauge predictor.
`timescale 1ns / 1ps

module tb_battery_gauge_low_alarm_top;
	import bgla_pkg::*;

	// Gauge arithmetic and alarm windows, written out as the block is specified.
	localparam int FLOOR_V          = 3498;
	localparam int SPAN_DIV         = 60;
	localparam int HIGH_KNEE        = 44;
	localparam int LOW_KNEE         = 3;
	localparam int KNEE_STEP        = 3;
	localparam int FULL_PCT         = 100;
	localparam int CHARGE_PER_PCT_S = 30;
	localparam int CHARGE_BASE_S    = 600;
	localparam int TWENTY_LO        = 19;
	localparam int TWENTY_HI        = 21;
	localparam int TEN_LO           = 9;
	localparam int TEN_HI           = 11;
	localparam int FIVE_LO          = 3;
	localparam int FIVE_HI          = 6;
	localparam int SHUT_BELOW       = 2;

	// Bit positions of the one-shot alarm flags.
	localparam int FLAG_TWENTY = 0;
	localparam int FLAG_TEN    = 1;
	localparam int FLAG_FIVE   = 2;

	localparam int RANDOM_WORDS = 1927;
	localparam int MAX_GAP      = 8;
	localparam int STALL_LIMIT  = 200;
	localparam int DRAIN_CYCLES = 4;

	typedef struct {
		req_t          kind;
		logic [9:0]    adc;
		logic          usb;
		logic          pwr;
		logic          typed;
		result_t       want;
	} stim_row_t;

	localparam result_t UNTYPED = '0;
	localparam int NUM_ROWS = 23;

	logic clk;
	logic arst_n;

	bgla_req_if req_bus ();
	bgla_rsp_if rsp_bus ();

	battery_gauge_low_alarm_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// Shadow copy of the gauge state, advanced once per accepted request word.
	logic [6:0] gauge_kept;
	logic [2:0] alarm_flags;
	stage_t     alert_stage;

	// Results owed by the block, oldest first.
	result_t gauge_due[$];
	int      fault_count;
	stim_row_t directed_rows[NUM_ROWS];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Corrected and capped percent that one raw sample stands for.
	function automatic int pct_from_adc(input logic [9:0] s);
		int sv;
		int v;
		int c;
		sv = int'(s);
		v  = 4 * sv + (2 * sv) / 10 + (2 * sv) / 100;
		if (v < FLOOR_V) begin
			v = FLOOR_V;
		end
		c = ((v - FLOOR_V) * 10) / SPAN_DIV;
		if (c > HIGH_KNEE) begin
			c = c + KNEE_STEP;
		end else if (c > LOW_KNEE) begin
			c = c - KNEE_STEP;
		end else begin
			c = 0;
		end
		if (c > FULL_PCT) begin
			c = FULL_PCT;
		end
		return c;
	endfunction

	// The kept percent is seeded while zero and afterwards only ever falls.
	function automatic void settle_kept(input int c);
		int k;
		k = int'(gauge_kept);
		if (k == 0) begin
			k = c;
		end else if (c < k) begin
			k = (k - c < 3) ? k - 1 : k - 2;
		end
		gauge_kept = 7'(k);
	endfunction

	function automatic void run_alarms(output logic alert, output logic shut);
		int k;
		k     = int'(gauge_kept);
		alert = 1'b0;
		shut  = 1'b0;
		if (k >= TWENTY_LO && k <= TWENTY_HI && !alarm_flags[FLAG_TWENTY]) begin
			alert_stage             = STAGE_ARMED;
			alarm_flags[FLAG_TWENTY] = 1'b1;
		end
		// The five percent alarm only gets a look when the ten percent one stayed quiet.
		if (k >= TEN_LO && k <= TEN_HI && !alarm_flags[FLAG_TEN]) begin
			alert_stage           = STAGE_ARMED;
			alarm_flags[FLAG_TEN] = 1'b1;
		end else if (k >= FIVE_LO && k <= FIVE_HI && !alarm_flags[FLAG_FIVE]) begin
			alert_stage            = STAGE_ARMED;
			alarm_flags[FLAG_FIVE] = 1'b1;
		end
		if (alert_stage == STAGE_READY) begin
			alert_stage = STAGE_IDLE;
			alert       = 1'b1;
		end else if (alert_stage == STAGE_ARMED) begin
			alert_stage = STAGE_READY;
		end else if (k < SHUT_BELOW) begin
			shut = 1'b1;
		end
	endfunction

	// Advances the shadow state by one request word and returns the result it owes.
	function automatic result_t gauge_advance(input req_t kind, input logic [9:0] adc,
		input logic usb, input logic pwr);
		result_t res;
		logic    live;
		logic    alert;
		logic    shut;
		res   = '0;
		alert = 1'b0;
		shut  = 1'b0;
		live  = !usb && pwr;
		case (kind)
			REQ_SAMPLE: begin
				if (live) begin
					settle_kept(pct_from_adc(adc));
					run_alarms(alert, shut);
				end
			end
			REQ_CONNECT: begin
				alarm_flags = '0;
				alert_stage = STAGE_IDLE;
			end
			REQ_DISCONNECT: begin
				gauge_kept = '0;
				settle_kept(pct_from_adc(adc));
				if (live) begin
					run_alarms(alert, shut);
				end
			end
			default: begin
				if (usb) begin
					res.full_charge_seconds =
						12'((FULL_PCT - int'(gauge_kept)) * CHARGE_PER_PCT_S + CHARGE_BASE_S);
				end
			end
		endcase
		res.battery_percent  = gauge_kept;
		res.low_alert        = alert;
		res.shutdown_request = shut;
		return res;
	endfunction

	task automatic note_fault(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fault_count++;
	endtask

	// Sender side. Valid is left high when no gap follows, so a back-to-back word
	// never sees valid lowered and raised within one time step.
	int  words_sent;
	logic send_free;

	task automatic push_word(input req_t kind, input logic [9:0] adc, input logic usb,
		input logic pwr, input logic typed, input result_t want);
		int      gap;
		result_t owed;
		if (words_sent % 50 == 0) begin
			send_free = ($urandom_range(0, 3) == 0);
		end
		gap = send_free ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid       <= 1'b1;
		req_bus.req_type    <= kind;
		req_bus.adc_sample  <= adc;
		req_bus.usb_present <= usb;
		req_bus.powered     <= pwr;
		do @(posedge clk); while (!req_bus.ready);
		// Accepted at this edge: the predictor steps in acceptance order.
		owed = gauge_advance(kind, adc, usb, pwr);
		gauge_due.push_back(typed ? want : owed);
		words_sent++;
	endtask

	// Main sequence: reset, directed table, random words, drain, verdict.
	initial begin
		int         pick;
		req_t       kind;
		logic [9:0] adc;
		logic       usb;
		logic       pwr;

		gauge_kept  = '0;
		alarm_flags = '0;
		alert_stage = STAGE_IDLE;
		fault_count = 0;
		words_sent  = 0;
		send_free   = 1'b0;

		req_bus.valid       <= 1'b0;
		req_bus.req_type    <= REQ_SAMPLE;
		req_bus.adc_sample  <= '0;
		req_bus.usb_present <= 1'b0;
		req_bus.powered     <= 1'b0;
		arst_n              <= 1'b0;

		// The first rows are readable straight off the spec; the rest walk the
		// kept percent through the twenty, ten and five percent windows, down to
		// a shutdown request and a reseed from zero.
		directed_rows = '{
			'{REQ_DEBOUNCE,   10'd0,    1'b1, 1'b1, 1'b1, '{7'd0,   1'b0, 1'b0, 12'd3600}},
			'{REQ_SAMPLE,     10'd0,    1'b0, 1'b1, 1'b1, '{7'd0,   1'b0, 1'b1, 12'd0}},
			'{REQ_DISCONNECT, 10'd1023, 1'b0, 1'b1, 1'b1, '{7'd100, 1'b0, 1'b0, 12'd0}},
			'{REQ_DEBOUNCE,   10'd0,    1'b1, 1'b1, 1'b1, '{7'd100, 1'b0, 1'b0, 12'd600}},
			'{REQ_DEBOUNCE,   10'd0,    1'b0, 1'b1, 1'b1, '{7'd100, 1'b0, 1'b0, 12'd0}},
			'{REQ_SAMPLE,     10'd0,    1'b1, 1'b1, 1'b1, '{7'd100, 1'b0, 1'b0, 12'd0}},
			'{REQ_SAMPLE,     10'd0,    1'b0, 1'b0, 1'b1, '{7'd100, 1'b0, 1'b0, 12'd0}},
			'{REQ_SAMPLE,     10'd1023, 1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_SAMPLE,     10'd0,    1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_DISCONNECT, 10'd864,  1'b1, 1'b0, 1'b0, UNTYPED},
			'{REQ_SAMPLE,     10'd864,  1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_SAMPLE,     10'd864,  1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_CONNECT,    10'd512,  1'b1, 1'b1, 1'b0, UNTYPED},
			'{REQ_SAMPLE,     10'd864,  1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_DISCONNECT, 10'd848,  1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_SAMPLE,     10'd848,  1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_DISCONNECT, 10'd841,  1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_SAMPLE,     10'd841,  1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_SAMPLE,     10'd0,    1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_SAMPLE,     10'd0,    1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_SAMPLE,     10'd0,    1'b0, 1'b1, 1'b0, UNTYPED},
			'{REQ_DEBOUNCE,   10'd1023, 1'b1, 1'b0, 1'b0, UNTYPED},
			'{REQ_DISCONNECT, 10'd0,    1'b0, 1'b0, 1'b0, UNTYPED}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			push_word(directed_rows[i].kind, directed_rows[i].adc, directed_rows[i].usb,
				directed_rows[i].pwr, directed_rows[i].typed, directed_rows[i].want);
		end

		// Random part. Most samples land in the span that moves the percent, so the
		// kept value keeps sliding through the alarm windows; disconnects reseed it
		// and connects re-enable the alarms. Plug and power flags add noise.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				kind = REQ_DISCONNECT;
			end else if (pick < 15) begin
				kind = REQ_CONNECT;
			end else if (pick < 30) begin
				kind = REQ_DEBOUNCE;
			end else begin
				kind = REQ_SAMPLE;
			end
			adc = ($urandom_range(0, 99) < 70) ? 10'($urandom_range(820, 975))
				: 10'($urandom_range(0, 1023));
			if (kind == REQ_DEBOUNCE) begin
				usb = 1'($urandom_range(0, 1));
			end else begin
				usb = ($urandom_range(0, 99) < 15);
			end
			pwr = ($urandom_range(0, 99) >= 15);
			push_word(kind, adc, usb, pwr, 1'b0, UNTYPED);
		end
		req_bus.valid <= 1'b0;

		while (gauge_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Receiver side: ready drops for a random number of cycles before each word,
	// with stretches where it stays high throughout.
	initial begin
		int   gap;
		int   taken;
		logic take_free;
		taken     = 0;
		take_free = 1'b0;
		rsp_bus.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (taken % 50 == 0) begin
				take_free = ($urandom_range(0, 3) == 0);
			end
			gap = take_free ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
			taken++;
		end
	end

	// Every result word taken is checked field by field against the oldest one owed.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (gauge_due.size() == 0) begin
				note_fault($sformatf("result word with nothing owed (percent %0d)",
					rsp_bus.battery_percent));
			end else begin
				want = gauge_due.pop_front();
				if (rsp_bus.battery_percent !== want.battery_percent) begin
					note_fault($sformatf("battery_percent got %0d want %0d",
						rsp_bus.battery_percent, want.battery_percent));
				end
				if (rsp_bus.low_alert !== want.low_alert) begin
					note_fault($sformatf("low_alert got %0b want %0b",
						rsp_bus.low_alert, want.low_alert));
				end
				if (rsp_bus.shutdown_request !== want.shutdown_request) begin
					note_fault($sformatf("shutdown_request got %0b want %0b",
						rsp_bus.shutdown_request, want.shutdown_request));
				end
				if (rsp_bus.full_charge_seconds !== want.full_charge_seconds) begin
					note_fault($sformatf("full_charge_seconds got %0d want %0d",
						rsp_bus.full_charge_seconds, want.full_charge_seconds));
				end
			end
		end
	end

	// Watchdog: a long run of cycles in which neither channel moves a word means
	// the block has hung.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
design/bgla_pkg.sv
design/bgla_req_if.sv
design/bgla_rsp_if.sv
design/bgla_state.sv
design/battery_gauge_low_alarm_top.sv
dv/tb_battery_gauge_low_alarm_top.sv
